[hw/rtl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

  // Table geometry and field widths
  localparam int DEPTH        = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int HANDLE_WIDTH = 16;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int ENTRY_W      = KEY_WIDTH + HANDLE_WIDTH;
  localparam int STATUS_W     = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_code_t;

  // Request type codes
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_ERASE  = 1'b1
  } req_code_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } eng_state_t;

  // Entry memory access from the sequencer
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HANDLE_WIDTH-1:0] removed_handle;
    logic [CNT_W-1:0]        entry_count;
  } result_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic    idle;
    logic    done;
    result_t result;
  } eng_stat_t;

endpackage

[hw/rtl/skt_if.sv]
`timescale 1ns / 1ps

// Request channel
interface skt_req_if
  import skt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [KEY_WIDTH-1:0]    key;
  logic [HANDLE_WIDTH-1:0] handle;

  modport source (output valid, req_type, key, handle, input ready);
  modport sink   (input valid, req_type, key, handle, output ready);
endinterface

// Result channel
interface skt_rsp_if
  import skt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [HANDLE_WIDTH-1:0] removed_handle;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, removed_handle, entry_count, input ready);
  modport sink   (input valid, status, removed_handle, entry_count, output ready);
endinterface

[hw/rtl/skt_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/skt_engine.sv]
`timescale 1ns / 1ps

// Sequencer: one key comparator shared by insertion shifting and binary search
module skt_engine
  import skt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    req_type,
  input  logic [KEY_WIDTH-1:0]    key,
  input  logic [HANDLE_WIDTH-1:0] handle,
  input  logic                    out_free,
  input  logic [ENTRY_W-1:0]      rdata,
  output mem_req_t                mem_req,
  output eng_stat_t               stat
);

  eng_state_t              state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [KEY_WIDTH-1:0]    req_key, req_key_next;
  logic [HANDLE_WIDTH-1:0] req_hnd, req_hnd_next;
  logic [CNT_W-1:0]        pos, pos_next;     // insert slot, then erase slot
  logic [CNT_W-1:0]        lo, lo_next;
  logic [CNT_W-1:0]        hi, hi_next;
  logic [CNT_W-1:0]        mid_q, mid_q_next;
  logic [STATUS_W-1:0]     status, status_next;
  logic [HANDLE_WIDTH-1:0] removed, removed_next;

  logic [KEY_WIDTH-1:0]    rd_key;
  logic [HANDLE_WIDTH-1:0] rd_hnd;
  logic                    key_eq, key_gt;
  logic [CNT_W-1:0]        pos_dec, pos_inc, mid;

  assign rd_key = rdata[ENTRY_W-1:HANDLE_WIDTH];
  assign rd_hnd = rdata[HANDLE_WIDTH-1:0];

  // Shared comparator: stored key against request key
  assign key_eq = (rd_key == req_key);
  assign key_gt = (rd_key > req_key);

  assign pos_dec = pos - 1'b1;
  assign pos_inc = pos + 1'b1;
  assign mid     = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    req_key <= req_key_next;
    req_hnd <= req_hnd_next;
    pos     <= pos_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid_q   <= mid_q_next;
    status  <= status_next;
    removed <= removed_next;
  end

  // Next state and memory control
  always_comb begin
    state_next    = state;
    count_next    = count;
    req_key_next  = req_key;
    req_hnd_next  = req_hnd;
    pos_next      = pos;
    lo_next       = lo;
    hi_next       = hi;
    mid_q_next    = mid_q;
    status_next   = status;
    removed_next  = removed;
    mem_req.we    = 1'b0;
    mem_req.waddr = pos[ADDR_W-1:0];
    mem_req.wdata = {req_key, req_hnd};
    mem_req.raddr = pos_dec[ADDR_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_key_next = key;
          req_hnd_next = handle;
          status_next  = STAT_DONE;
          removed_next = '0;
          pos_next     = count;
          lo_next      = '0;
          hi_next      = count;
          if (req_type == REQ_ERASE) begin
            state_next = S_SRCH_RD;
          end else if (count == CNT_W'(DEPTH)) begin
            status_next = STAT_FULL;
            state_next  = S_FINISH;
          end else begin
            state_next = S_INS_RD;
          end
        end
      end

      // Read the entry above the slot, or drop the new entry at the top
      S_INS_RD: begin
        if (pos == '0) begin
          mem_req.we = 1'b1;
          count_next = count + 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_INS_CMP;
        end
      end

      // Move a greater entry down one place, or place the new entry
      S_INS_CMP: begin
        mem_req.we = 1'b1;
        if (key_gt) begin
          mem_req.wdata = rdata;
          pos_next      = pos_dec;
          state_next    = S_INS_RD;
        end else begin
          count_next = count + 1'b1;
          state_next = S_FINISH;
        end
      end

      // Probe the middle of the remaining range
      S_SRCH_RD: begin
        mem_req.raddr = mid[ADDR_W-1:0];
        mid_q_next    = mid;
        if (lo < hi) begin
          state_next = S_SRCH_CMP;
        end else begin
          status_next = STAT_NOT_FOUND;
          state_next  = S_FINISH;
        end
      end

      S_SRCH_CMP: begin
        if (key_eq) begin
          removed_next = rd_hnd;
          pos_next     = mid_q;
          state_next   = S_DEL_RD;
        end else begin
          if (key_gt) begin
            hi_next = mid_q;
          end else begin
            lo_next = mid_q + 1'b1;
          end
          state_next = S_SRCH_RD;
        end
      end

      // Close the gap one entry at a time
      S_DEL_RD: begin
        mem_req.raddr = pos_inc[ADDR_W-1:0];
        if (pos_inc < count) begin
          state_next = S_DEL_WR;
        end else begin
          count_next = count - 1'b1;
          state_next = S_FINISH;
        end
      end

      S_DEL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = rdata;
        pos_next      = pos_inc;
        state_next    = S_DEL_RD;
      end

      // Hold the result until the output register can take it
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign stat.idle                  = (state == S_IDLE);
  assign stat.done                  = (state == S_FINISH);
  assign stat.result.status         = status;
  assign stat.result.removed_handle = removed;
  assign stat.result.entry_count    = count;

endmodule

[hw/rtl/sorted_key_table.sv]
`timescale 1ns / 1ps
// Insert: moves each greater entry down one place, then writes the new entry; a full
// table refuses the insert. Erase: binary search of at most 7 probes, then each later
// entry moves up one place to close the gap. Both run a read/compare/write loop over the
// entry memory. Throughput: one item at a time; a new request is accepted only once the
// result of the last has been taken into the result register.
// Reset clears the fill count and the handshake state; the entry memory is not cleared.

module sorted_key_table
  import skt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  skt_req_if.sink  req,
  skt_rsp_if.source rsp
);

  mem_req_t       mem_req;
  eng_stat_t      eng_stat;
  logic [ENTRY_W-1:0] rdata;
  logic           out_free;
  logic           out_valid;
  result_t        out_data;

  // Output register frees when empty or being taken
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = eng_stat.idle;

  skt_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid && req.ready),
    .req_type (req.req_type),
    .key      (req.key),
    .handle   (req.handle),
    .out_free (out_free),
    .rdata    (rdata),
    .mem_req  (mem_req),
    .stat     (eng_stat)
  );

  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= eng_stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && eng_stat.done) begin
      out_data <= eng_stat.result;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_data.status;
  assign rsp.removed_handle = out_data.removed_handle;
  assign rsp.entry_count    = out_data.entry_count;

  // One request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // Refused insert only when the table is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_FULL) |-> (rsp.entry_count == CNT_W'(DEPTH)))
    else $error("full status with table not full");

  // Missed erase returns no handle
  a_miss_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_NOT_FOUND) |-> (rsp.removed_handle == '0))
    else $error("handle returned on missed erase");

  // Fill count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    eng_stat.result.entry_count <= CNT_W'(DEPTH))
    else $error("fill count beyond capacity");

endmodule
